// ===== hw/rtl/bcbg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcbg_pkg: shared types and constants for the buffer cache block getter
// Status codes, controller states and the command/status structs.
// ---------------------------------------------------------------------------
package bcbg_pkg;
	localparam int NUM_BUFFERS_DEF = 32;
	localparam int BLK_W = 16;
	localparam int SLOT_W = 5;

	typedef enum logic [2:0] {
		ST_HIT = 3'd0,
		ST_BUSY = 3'd1,
		ST_REASSIGNED = 3'd2,
		ST_WRITE = 3'd3,
		ST_NOFREE = 3'd4,
		ST_LOADED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SEARCH,
		S_WALK,
		S_DROP,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic latch;    // capture input item
		logic do_load;  // write table entry, drop slot, maybe append
		logic do_hit;   // lock hit entry, drop slot
		logic do_write; // head delayed: clear delayed bit, pop head
		logic do_reasg; // reassign head, pop head
		logic out_load;
		logic out_hit;
		logic out_busy;
		logic out_write;
		logic out_reasg;
		logic out_nofree;
	} bcbg_cmd_t;

	typedef struct packed {
		logic action;
		logic idx_ok;
		logic hit;
		logic hit_locked;
		logic list_empty;
		logic head_delayed;
		logic shifting; // free list compaction or tail append in progress
	} bcbg_stat_t;
endpackage

// ===== hw/rtl/buffer_cache_block_getter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// buffer_cache_block_getter: buffer cache lookup and free-list manager
// Load fills a table entry; request hits and locks, reports busy, or reclaims a free buffer.
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  s_axis  | in  | tdata {load_free, load_delayed, load_locked, entry_index,
//          |     |   block_id}, tuser action
//  m_axis  | out | tdata {old_block, result_slot, result_block}, tuser status,
//          |     |   tlast last
//
//  Load: written in S_LOAD; a slot that was already listed leaves the list by
//    compaction, and a free, unlocked slot is then appended at the tail.
//  Request hit/busy: S_LOAD and S_SEARCH, plus compaction when a listed buffer is hit.
//  Miss: S_SEARCH, then S_WALK; each written-out head passes S_DROP and waits for
//    compaction; reassign passes S_EMIT; no free buffer ends in S_WALK.
//  Reset clears all valid bits and the free count; no clearing pass.
//  A stalled output holds the controller before it issues the next result.
module buffer_cache_block_getter import bcbg_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata, // block_id[15:0], entry_index[20:16], load_locked[21],
	                                  // load_delayed[22], load_free[23]
	input  logic [0:0]  s_axis_tuser, // action[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata, // result_block[15:0], result_slot[20:16],
	                                  // old_block[36:21]
	output logic [2:0]  m_axis_tuser, // status[2:0]
	output logic        m_axis_tlast
);
	bcbg_cmd_t cmd;
	bcbg_stat_t stat;

	bcbg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.res_valid(m_axis_tvalid && !m_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	bcbg_datapath #(.NUM_BUFFERS(NUM_BUFFERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_data(s_axis_tdata), .in_user(s_axis_tuser),
		.res_valid(m_axis_tvalid), .res_take(m_axis_tready),
		.res_data(m_axis_tdata), .res_user(m_axis_tuser), .res_last(m_axis_tlast)
	);
endmodule

// ===== hw/rtl/bcbg_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcbg_datapath: buffer table, free list and result register
// Free-list removal compacts one position per cycle.
// ---------------------------------------------------------------------------
module bcbg_datapath import bcbg_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bcbg_cmd_t         cmd,
	output bcbg_stat_t        stat,
	input  logic [23:0]       in_data,
	input  logic [0:0]        in_user,
	output logic              res_valid,
	input  logic              res_take,
	output logic [39:0]       res_data,
	output logic [2:0]        res_user,
	output logic              res_last
);
	localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
	localparam int IDX_W = $clog2(NUM_BUFFERS);

	logic [NUM_BUFFERS-1:0] valid_q, locked_q, delayed_q;
	logic [BLK_W-1:0] blk_q [NUM_BUFFERS];
	logic [SLOT_W-1:0] order_q [NUM_BUFFERS];
	logic [CNT_W-1:0] count_q, shpos_q;
	logic shifting_q;
	logic app_pend_q; // loaded slot still to be appended once compaction settles

	logic action_q, lk_q, dl_q, fr_q;
	logic [BLK_W-1:0] req_blk_q;
	logic [SLOT_W-1:0] req_idx_q;

	// match search
	logic hit;
	logic [IDX_W-1:0] hit_slot;
	always_comb begin
		hit = 1'b0;
		hit_slot = '0;
		for (int s = NUM_BUFFERS - 1; s >= 0; s--) begin
			if (valid_q[s] && blk_q[s] == req_blk_q) begin
				hit = 1'b1;
				hit_slot = IDX_W'(s);
			end
		end
	end

	logic idx_ok;
	assign idx_ok = {1'b0, req_idx_q} < (SLOT_W + 1)'(NUM_BUFFERS);
	logic [IDX_W-1:0] ld_slot;
	assign ld_slot = IDX_W'(req_idx_q);

	// free list position of a slot
	logic [IDX_W-1:0] find_slot;
	logic found;
	logic [CNT_W-1:0] found_pos;
	assign find_slot = cmd.do_load ? ld_slot : hit_slot;
	always_comb begin
		found = 1'b0;
		found_pos = '0;
		for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
			if (CNT_W'(i) < count_q && order_q[i] == SLOT_W'(find_slot)) begin
				found = 1'b1;
				found_pos = CNT_W'(i);
			end
		end
	end

	logic [IDX_W-1:0] head;
	assign head = IDX_W'(order_q[0]);

	assign stat.action = action_q;
	assign stat.idx_ok = idx_ok;
	assign stat.hit = hit;
	assign stat.hit_locked = locked_q[hit_slot];
	assign stat.list_empty = count_q == '0;
	assign stat.head_delayed = delayed_q[head];
	assign stat.shifting = shifting_q | app_pend_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= in_user[0];
			req_blk_q <= in_data[15:0];
			req_idx_q <= in_data[20:16];
			lk_q <= in_data[21];
			dl_q <= in_data[22];
			fr_q <= in_data[23];
		end
		if (cmd.do_load)
			blk_q[ld_slot] <= req_blk_q;
		if (cmd.do_reasg)
			blk_q[head] <= req_blk_q;
		// compaction: move one entry down per cycle
		if (shifting_q && shpos_q < count_q)
			order_q[shpos_q[IDX_W-1:0]] <= order_q[shpos_q[IDX_W-1:0] + 1'b1];
		// tail append after any compaction has finished
		if (app_pend_q && !shifting_q)
			order_q[count_q[IDX_W-1:0]] <= SLOT_W'(ld_slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			locked_q <= '0;
			delayed_q <= '0;
			count_q <= '0;
			shpos_q <= '0;
			shifting_q <= 1'b0;
			app_pend_q <= 1'b0;
		end else begin
			if (shifting_q) begin
				if (shpos_q + 1'b1 >= count_q)
					shifting_q <= 1'b0;
				shpos_q <= shpos_q + 1'b1;
			end
			if (app_pend_q && !shifting_q) begin
				count_q <= count_q + 1'b1;
				app_pend_q <= 1'b0;
			end
			if (cmd.do_load) begin
				valid_q[ld_slot] <= 1'b1;
				locked_q[ld_slot] <= lk_q;
				delayed_q[ld_slot] <= dl_q;
				if (found) begin
					shpos_q <= found_pos;
					shifting_q <= 1'b1;
					count_q <= count_q - 1'b1;
				end
				if (fr_q && !lk_q)
					app_pend_q <= 1'b1;
			end
			if (cmd.do_hit) begin
				locked_q[hit_slot] <= 1'b1;
				delayed_q[hit_slot] <= 1'b0;
				if (found) begin
					shpos_q <= found_pos;
					shifting_q <= 1'b1;
					count_q <= count_q - 1'b1;
				end
			end
			if (cmd.do_write || cmd.do_reasg) begin
				delayed_q[head] <= 1'b0;
				shpos_q <= '0;
				shifting_q <= 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.do_reasg) begin
				valid_q[head] <= 1'b1;
				locked_q[head] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (cmd.out_load | cmd.out_hit | cmd.out_busy | cmd.out_write |
			cmd.out_reasg | cmd.out_nofree)
			res_valid <= 1'b1;
		else if (res_take)
			res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_user <= ST_LOADED;
			res_data <= {3'd0, BLK_W'(0), req_idx_q, req_blk_q};
			res_last <= 1'b1;
		end else if (cmd.out_hit || cmd.out_busy) begin
			res_user <= cmd.out_hit ? ST_HIT : ST_BUSY;
			res_data <= {3'd0, BLK_W'(0), SLOT_W'(hit_slot), req_blk_q};
			res_last <= 1'b1;
		end else if (cmd.out_write) begin
			res_user <= ST_WRITE;
			res_data <= {3'd0, BLK_W'(0), SLOT_W'(head), blk_q[head]};
			res_last <= 1'b0;
		end else if (cmd.out_reasg) begin
			res_user <= ST_REASSIGNED;
			res_data <= {3'd0, blk_q[head], SLOT_W'(head), req_blk_q};
			res_last <= 1'b1;
		end else if (cmd.out_nofree) begin
			res_user <= ST_NOFREE;
			res_data <= {3'd0, BLK_W'(0), SLOT_W'(0), req_blk_q};
			res_last <= 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_BUFFERS))
		else $error("free count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_write || cmd.do_reasg) |-> !stat.list_empty && !shifting_q)
		else $error("pop of empty or unsettled free list");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_hit |-> hit && !locked_q[hit_slot])
		else $error("lock of locked or absent buffer");
endmodule

// ===== hw/rtl/bcbg_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcbg_ctrl: sequencing of load, search and free-list walk
// A miss may emit write-outs first; waits for list compaction to settle.
// ---------------------------------------------------------------------------
module bcbg_ctrl import bcbg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       res_valid,
	input  bcbg_stat_t stat,
	output bcbg_cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !stat.shifting;
				if (in_valid && !stat.shifting) begin
					cmd.latch = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (!res_valid) begin
					if (stat.action) begin
						if (stat.idx_ok) begin
							cmd.do_load = 1'b1;
							cmd.out_load = 1'b1;
						end
						state_d = S_IDLE;
					end else
						state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (stat.hit) begin
					if (stat.hit_locked)
						cmd.out_busy = 1'b1;
					else begin
						cmd.do_hit = 1'b1;
						cmd.out_hit = 1'b1;
					end
					state_d = S_IDLE;
				end else
					state_d = S_WALK;
			end
			S_WALK: begin
				if (!stat.shifting && !res_valid) begin
					if (stat.list_empty) begin
						cmd.out_nofree = 1'b1;
						state_d = S_IDLE;
					end else if (stat.head_delayed) begin
						cmd.out_write = 1'b1;
						state_d = S_DROP;
					end else begin
						cmd.out_reasg = 1'b1;
						state_d = S_EMIT;
					end
				end
			end
			S_DROP: begin
				cmd.do_write = 1'b1;
				state_d = S_WALK;
			end
			S_EMIT: begin
				cmd.do_reasg = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== sim/buffer_cache_block_getter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// buffer_cache_block_getter_tb: self-checking bench for the buffer cache
// Drives load and request transfers with random gaps, predicts the result
// stream from an internal copy of the table and free list, and checks it.
// ---------------------------------------------------------------------------

class cache_scoreboard;
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] blk;
		logic [4:0]  slot;
		logic [15:0] old_blk;
		logic        fin;
	} cache_result_t;

	bit          valid_q[32];
	bit [15:0]   blk_q[32];
	bit          locked_q[32];
	bit          delayed_q[32];
	bit          writing_q[32];
	int          spare_slots[$];
	cache_result_t pending[$];
	int          errors;

	function new();
		for (int i = 0; i < 32; i++) begin
			valid_q[i] = 0; blk_q[i] = 0; locked_q[i] = 0;
			delayed_q[i] = 0; writing_q[i] = 0;
		end
		errors = 0;
	endfunction

	function void push(bcbg_pkg::status_t st, bit [15:0] b, bit [4:0] s, bit [15:0] o,
			bit f);
		cache_result_t r;
		r.status = st; r.blk = b; r.slot = s; r.old_blk = o; r.fin = f;
		pending.insert(pending.size(), r);
	endfunction

	function void unlist(int s);
		foreach (spare_slots[i]) begin
			if (spare_slots[i] == s) begin
				spare_slots.delete(i);
				return;
			end
		end
	endfunction

	function bit is_free(int s);
		foreach (spare_slots[i]) if (spare_slots[i] == s) return 1;
		return 0;
	endfunction

	// note an accepted input transfer and queue what it must produce
	function void note_input(bit act, bit [15:0] b, bit [4:0] idx, bit lk, bit dl, bit fr);
		int h;
		int found;
		bit [15:0] old;
		if (act) begin
			unlist(idx);
			valid_q[idx] = 1; blk_q[idx] = b; locked_q[idx] = lk;
			delayed_q[idx] = dl; writing_q[idx] = 0;
			if (fr && !lk && spare_slots.size() < 32)
				spare_slots.insert(spare_slots.size(), int'(idx));
			push(bcbg_pkg::ST_LOADED, b, idx, 16'd0, 1'b1);
			return;
		end
		found = -1;
		for (int s = 0; s < 32; s++)
			if (found < 0 && valid_q[s] && blk_q[s] == b) found = s;
		if (found >= 0) begin
			if (locked_q[found]) begin
				push(bcbg_pkg::ST_BUSY, b, 5'(found), 16'd0, 1'b1);
			end else begin
				locked_q[found] = 1; delayed_q[found] = 0;
				unlist(found);
				push(bcbg_pkg::ST_HIT, b, 5'(found), 16'd0, 1'b1);
			end
			return;
		end
		// miss: flush delayed buffers at the head, then reclaim the next
		while (spare_slots.size() > 0 && delayed_q[spare_slots[0]]) begin
			h = spare_slots.pop_front();
			delayed_q[h] = 0; writing_q[h] = 1;
			push(bcbg_pkg::ST_WRITE, blk_q[h], 5'(h), 16'd0, 1'b0);
		end
		if (spare_slots.size() == 0) begin
			push(bcbg_pkg::ST_NOFREE, b, 5'd0, 16'd0, 1'b1);
			return;
		end
		h = spare_slots.pop_front();
		old = blk_q[h];
		valid_q[h] = 1; blk_q[h] = b; locked_q[h] = 1; delayed_q[h] = 0; writing_q[h] = 0;
		push(bcbg_pkg::ST_REASSIGNED, b, 5'(h), old, 1'b1);
	endfunction

	function void check_result(logic [2:0] st, logic [39:0] data, logic tl);
		cache_result_t e;
		if (pending.size() == 0) begin
			$error("unexpected result %h", data);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (st !== e.status) begin
			$error("status exp %0d got %0d", e.status, st); errors++;
		end
		if (data[15:0] !== e.blk) begin
			$error("result_block exp %0d got %0d", e.blk, data[15:0]); errors++;
		end
		if (data[20:16] !== e.slot) begin
			$error("result_slot exp %0d got %0d", e.slot, data[20:16]); errors++;
		end
		if (data[36:21] !== e.old_blk) begin
			$error("old_block exp %0d got %0d", e.old_blk, data[36:21]); errors++;
		end
		if (tl !== e.fin) begin
			$error("last exp %0d got %0d", e.fin, tl); errors++;
		end
	endfunction
endclass

module buffer_cache_block_getter_tb import bcbg_pkg::*; ();

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // block_id, entry_index, load_locked, load_delayed, load_free
	logic [0:0]  s_axis_tuser;  // action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // result_block, result_slot, old_block
	logic [2:0]  m_axis_tuser;  // status
	logic        m_axis_tlast;

	cache_scoreboard board;
	bit  hold_sink;       // receiver long hold-off request
	int  sink_phase;      // 0 normal, 1 no gaps

	buffer_cache_block_getter dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// overall limit: generous beyond worst case stalls and walks
	initial begin
		#100ms;
		$display("FAIL");
		$finish;
	end

	int gap_mode;  // 0 random gaps, 1 none

	// one input transfer; gap drawn before it, then held until accepted
	task automatic send_item(bit act, bit [15:0] b, bit [4:0] idx, bit lk, bit dl, bit fr);
		int gap;
		gap = (gap_mode == 1) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {fr, dl, lk, idx, b};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_input(act, b, idx, lk, dl, fr);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// receiver: random ready per transfer, with an optional long hold-off
	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_axis_tready <= 0;
				repeat (400) @(negedge clk);
				hold_sink = 0;
			end
			gap = (sink_phase == 1) ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
		end
	end

	// well-formed traffic mostly: ids from a small pool so hits and walks recur
	task automatic random_item();
		int r;
		bit [15:0] b;
		r = $urandom_range(0, 99);
		b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		if (r < 40)
			send_item(1'b1, b, 5'($urandom), $urandom_range(0, 3) == 0,
				1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
		else
			send_item(1'b0, b, 5'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
	endtask

	initial begin
		board = new();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		hold_sink = 0;
		sink_phase = 0;
		gap_mode = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty list, loads at extremes, hits, busy, flush, reclaim
		send_item(1'b0, 16'hFFFF, 5'd0, 1'b0, 1'b0, 1'b0);  // no free buffer
		send_item(1'b1, 16'h0000, 5'd0, 1'b0, 1'b1, 1'b1);  // delayed, listed
		send_item(1'b1, 16'hFFFF, 5'd31, 1'b0, 1'b0, 1'b1);
		send_item(1'b1, 16'h1234, 5'd5, 1'b1, 1'b1, 1'b1);  // locked ignores free
		send_item(1'b1, 16'h0000, 5'd7, 1'b0, 1'b0, 1'b1);  // duplicate id
		send_item(1'b0, 16'h1234, 5'd0, 1'b0, 1'b0, 1'b0);  // busy
		send_item(1'b0, 16'hFFFF, 5'd0, 1'b0, 1'b0, 1'b0);  // hit, leaves list
		send_item(1'b0, 16'h0000, 5'd0, 1'b0, 1'b0, 1'b0);  // lowest slot hit
		send_item(1'b1, 16'h0042, 5'd0, 1'b0, 1'b1, 1'b1);  // reload hit slot, listed again
		send_item(1'b1, 16'h0043, 5'd1, 1'b0, 1'b1, 1'b1);
		send_item(1'b1, 16'h0044, 5'd2, 1'b0, 1'b0, 1'b1);
		send_item(1'b1, 16'h0045, 5'd0, 1'b0, 1'b1, 1'b1);  // reload moves to tail
		send_item(1'b0, 16'h0100, 5'd0, 1'b0, 1'b0, 1'b0);  // reclaim undelayed head, no write out
		send_item(1'b0, 16'h0101, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(1'b0, 16'h0102, 5'd0, 1'b0, 1'b0, 1'b0);
		for (int i = 0; i < 32; i++)
			send_item(1'b1, 16'(i + 200), 5'(i), 1'b0, 1'b1, 1'b1);
		send_item(1'b0, 16'h7777, 5'd0, 1'b0, 1'b0, 1'b0);  // long walk: 32 writes, no free
		wait_drained();

		// long receiver hold-off while sender keeps offering
		hold_sink = 1;
		gap_mode = 1;
		for (int i = 0; i < 20; i++) random_item();
		gap_mode = 0;
		wait_drained();

		for (int i = 0; i < 310; i++) begin
			if (i == 150) sink_phase = 1;
			if (i == 200) begin
				sink_phase = 0;
				gap_mode = 1;
			end
			if (i == 240) gap_mode = 0;
			random_item();
		end
		wait_drained();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
